// ===== sv/rob_pkg.sv =====
// ----------------------------------------------------------------------------
// rob_pkg: shared definitions for the rectangle overlap best-match core
// Field widths, operation codes, reset constants, sequencer states and the
// control bundle that the top level hands to the scoring unit.
// ----------------------------------------------------------------------------
package rob_pkg;

    localparam int TABLE_SLOTS_DEF = 16;
    localparam int COORD_BITS_DEF  = 12;

    localparam int FIELD_COORD_W = 12;
    localparam int SLOT_FIELD_W  = 4;
    localparam int THRESH_W      = 16;
    localparam int RATIO_OUT_W   = 17;
    localparam int Q_BITS        = 17;
    localparam int DIV_CNT_W     = 5;

    localparam logic [THRESH_W-1:0]    THRESH_RESET = 16'd22938;
    localparam logic [RATIO_OUT_W-1:0] Q16_ONE      = 17'd65536;

    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GEO,
        ST_AREA,
        ST_XLO,
        ST_XHI,
        ST_CMP,
        ST_FIN,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic init;
        logic geo;
        logic area;
        logic xlo;
        logic xhi;
        logic cmp;
    } t_score_ctrl;

endpackage

// ===== sv/rob_cell.sv =====
// ----------------------------------------------------------------------------
// rob_cell: one table slot in the rotating slot ring
// Holds a valid mark and a rectangle. Loads from the write port or takes the
// contents of its neighbor when the ring shifts.
// ----------------------------------------------------------------------------
module rob_cell #(
    parameter int DATA_W = 49
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_shift,
    input  logic [DATA_W-1:0] i_load_data,
    input  logic [DATA_W-1:0] i_next_data,
    output logic [DATA_W-1:0] o_data
);

    logic              r_valid;
    logic [DATA_W-2:0] r_rect;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_load_data[DATA_W-1];
        end else if (i_shift) begin
            r_valid <= i_next_data[DATA_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rect <= i_load_data[DATA_W-2:0];
        end else if (i_shift) begin
            r_rect <= i_next_data[DATA_W-2:0];
        end
    end

    assign o_data = {r_valid, r_rect};

endmodule

// ===== sv/rob_score.sv =====
// ----------------------------------------------------------------------------
// rob_score: shared overlap scoring unit
// Computes intersection and bounding-box areas for the slot at the head of
// the ring, compares the ratio exactly against the best so far by
// cross-multiplication in split partial products, and keeps the best match.
// ----------------------------------------------------------------------------
module rob_score #(
    parameter int COORD_BITS = rob_pkg::COORD_BITS_DEF,
    parameter int SLOT_W     = 4,
    localparam int EW        = COORD_BITS + 1,
    localparam int AW        = 2 * EW,
    localparam int RW        = (AW > rob_pkg::RATIO_OUT_W) ? AW : rob_pkg::RATIO_OUT_W,
    localparam int HW        = (RW + 1) / 2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rob_pkg::t_score_ctrl          i_ctrl,
    input  logic [rob_pkg::THRESH_W-1:0]  i_thr,
    input  logic [4*COORD_BITS-1:0]       i_query,
    input  logic [4*COORD_BITS:0]         i_slot_data,
    input  logic [SLOT_W-1:0]             i_cand_idx,
    output logic                          o_found,
    output logic [SLOT_W-1:0]             o_best_slot,
    output logic [RW-1:0]                 o_best_num,
    output logic [RW-1:0]                 o_best_den
);

    logic [COORD_BITS-1:0] qx, qy, qw, qh, sx, sy, sw, sh;
    logic                  s_valid;
    logic [EW-1:0]         qx1, qy1, sx1, sy1;
    logic [COORD_BITS-1:0] ix0, iy0, bx0, by0;
    logic [EW-1:0]         ix1, iy1, bx1, by1;
    logic                  ok;

    logic                  r_ok;
    logic [EW-1:0]         r_iw, r_ih, r_bw, r_bh;
    logic [SLOT_W-1:0]     r_cand;
    logic [AW-1:0]         inter_p, bbox_p;
    logic [RW-1:0]         r_inter, r_bbox;
    logic [HW+RW-1:0]      r_pa_lo, r_pc_lo;
    logic [2*RW-HW-1:0]    r_pa_hi, r_pc_hi;
    logic [2*RW-1:0]       pa, pc;
    logic                  r_found;
    logic [SLOT_W-1:0]     r_best_slot;
    logic [RW-1:0]         r_best_num, r_best_den;

    assign qx = i_query[4*COORD_BITS-1 -: COORD_BITS];
    assign qy = i_query[3*COORD_BITS-1 -: COORD_BITS];
    assign qw = i_query[2*COORD_BITS-1 -: COORD_BITS];
    assign qh = i_query[COORD_BITS-1:0];
    assign s_valid = i_slot_data[4*COORD_BITS];
    assign sx = i_slot_data[4*COORD_BITS-1 -: COORD_BITS];
    assign sy = i_slot_data[3*COORD_BITS-1 -: COORD_BITS];
    assign sw = i_slot_data[2*COORD_BITS-1 -: COORD_BITS];
    assign sh = i_slot_data[COORD_BITS-1:0];

    assign qx1 = {1'b0, qx} + {1'b0, qw};
    assign qy1 = {1'b0, qy} + {1'b0, qh};
    assign sx1 = {1'b0, sx} + {1'b0, sw};
    assign sy1 = {1'b0, sy} + {1'b0, sh};

    assign ix0 = (qx > sx) ? qx : sx;
    assign iy0 = (qy > sy) ? qy : sy;
    assign ix1 = (qx1 < sx1) ? qx1 : sx1;
    assign iy1 = (qy1 < sy1) ? qy1 : sy1;
    assign bx0 = (qx < sx) ? qx : sx;
    assign by0 = (qy < sy) ? qy : sy;
    assign bx1 = (qx1 > sx1) ? qx1 : sx1;
    assign by1 = (qy1 > sy1) ? qy1 : sy1;

    assign ok = s_valid && (qw != '0) && (qh != '0) && (sw != '0) && (sh != '0)
             && (ix1 > {1'b0, ix0}) && (iy1 > {1'b0, iy0});

    always_ff @(posedge i_clk) begin
        if (i_ctrl.geo) begin
            r_ok   <= ok;
            r_iw   <= ix1 - {1'b0, ix0};
            r_ih   <= iy1 - {1'b0, iy0};
            r_bw   <= bx1 - {1'b0, bx0};
            r_bh   <= by1 - {1'b0, by0};
            r_cand <= i_cand_idx;
        end
    end

    assign inter_p = r_iw * r_ih;
    assign bbox_p  = r_bw * r_bh;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.area) begin
            r_inter <= RW'(inter_p);
            r_bbox  <= RW'(bbox_p);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.xlo) begin
            r_pa_lo <= r_inter[HW-1:0] * r_best_den;
            r_pc_lo <= r_best_num[HW-1:0] * r_bbox;
        end
        if (i_ctrl.xhi) begin
            r_pa_hi <= r_inter[RW-1:HW] * r_best_den;
            r_pc_hi <= r_best_num[RW-1:HW] * r_bbox;
        end
    end

    assign pa = (2*RW)'(r_pa_lo) + ((2*RW)'(r_pa_hi) << HW);
    assign pc = (2*RW)'(r_pc_lo) + ((2*RW)'(r_pc_hi) << HW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctrl.init) begin
            r_found <= 1'b0;
        end else if (i_ctrl.cmp && r_ok && (pa > pc)) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.init) begin
            r_best_num  <= RW'(i_thr);
            r_best_den  <= RW'(rob_pkg::Q16_ONE);
            r_best_slot <= '0;
        end else if (i_ctrl.cmp && r_ok && (pa > pc)) begin
            r_best_num  <= r_inter;
            r_best_den  <= r_bbox;
            r_best_slot <= r_cand;
        end
    end

    assign o_found     = r_found;
    assign o_best_slot = r_best_slot;
    assign o_best_num  = r_best_num;
    assign o_best_den  = r_best_den;

endmodule

// ===== sv/rob_div.sv =====
// ----------------------------------------------------------------------------
// rob_div: iterative ratio divider
// Produces floor(num * 65536 / den) for num not above den by restoring
// long division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rob_div #(
    parameter int RW = 26
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [RW-1:0]                   i_num,
    input  logic [RW-1:0]                   i_den,
    output logic                            o_done,
    output logic [rob_pkg::RATIO_OUT_W-1:0] o_quot
);

    logic                            r_busy;
    logic                            r_done;
    logic [rob_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [RW:0]                     r_rem;
    logic [RW-1:0]                   r_den;
    logic [rob_pkg::Q_BITS-1:0]      r_quot;
    logic                            ge;
    logic [RW:0]                     diff;
    logic                            last;

    assign ge   = r_rem >= {1'b0, r_den};
    assign diff = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    assign last = r_cnt == rob_pkg::DIV_CNT_W'(rob_pkg::Q_BITS - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && last;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (last) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= {diff[RW-1:0], 1'b0};
            r_quot <= {r_quot[rob_pkg::Q_BITS-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = rob_pkg::RATIO_OUT_W'(r_quot);

endmodule

// ===== sv/rect_overlap_best_match_core.sv =====
// ----------------------------------------------------------------------------
// rect_overlap_best_match_core: best-overlap search over tracked rectangles
// A ring of slot cells rotates one slot per scoring pass past a shared
// overlap unit; an iterative divider forms the reported Q1.16 ratio.
//
//   channel  direction  handshake               payload
//   in       input      i_in_valid / o_in_stall  func, slot, entry_valid, rect
//   out      output     o_out_valid / i_out_stall found, match_slot, best_ratio
//   cfg      input      i_cfg_valid / o_cfg_ready iou_threshold
//
// A write beat's result is registered at acceptance.
// A query runs each slot through five steps in the overlap unit (geometry,
// area, low and high cross products, compare), plus the divider on a match.
// Reset clears every valid mark and restores the threshold at once.
// A new beat is taken only when the block is idle and the output register is
// free or drains in the same cycle.
// ----------------------------------------------------------------------------
module rect_overlap_best_match_core #(
    parameter int TABLE_SLOTS = rob_pkg::TABLE_SLOTS_DEF,
    parameter int COORD_BITS  = rob_pkg::COORD_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_func,
    input  logic [rob_pkg::SLOT_FIELD_W-1:0]  i_slot,
    input  logic                              i_entry_valid,
    input  logic [rob_pkg::FIELD_COORD_W-1:0] i_rect_x,
    input  logic [rob_pkg::FIELD_COORD_W-1:0] i_rect_y,
    input  logic [rob_pkg::FIELD_COORD_W-1:0] i_rect_w,
    input  logic [rob_pkg::FIELD_COORD_W-1:0] i_rect_h,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_found,
    output logic [rob_pkg::SLOT_FIELD_W-1:0]  o_match_slot,
    output logic [rob_pkg::RATIO_OUT_W-1:0]   o_best_ratio,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rob_pkg::THRESH_W-1:0]      i_cfg_data
);

    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int DATA_W = 4 * COORD_BITS + 1;
    localparam int EW     = COORD_BITS + 1;
    localparam int AW     = 2 * EW;
    localparam int RW     = (AW > rob_pkg::RATIO_OUT_W) ? AW : rob_pkg::RATIO_OUT_W;

    rob_pkg::t_state      r_state, n_state;
    rob_pkg::t_score_ctrl score_ctrl;

    logic [rob_pkg::THRESH_W-1:0]    r_thr;
    logic [SLOT_W-1:0]               r_idx;
    logic [4*COORD_BITS-1:0]         r_query;
    logic [DATA_W-1:0]               load_data;
    logic [DATA_W-1:0]               cell_data [TABLE_SLOTS];
    logic                            in_acc;
    logic                            wr_acc;
    logic                            ring_shift;
    logic                            div_start;
    logic                            div_done;
    logic [rob_pkg::RATIO_OUT_W-1:0] div_quot;
    logic                            best_found;
    logic [SLOT_W-1:0]               best_slot;
    logic [RW-1:0]                   best_num, best_den;
    logic                            out_zero_ld;
    logic                            out_match_ld;
    logic                            last_slot;

    logic                              r_out_valid;
    logic                              r_found;
    logic [rob_pkg::SLOT_FIELD_W-1:0]  r_match_slot;
    logic [rob_pkg::RATIO_OUT_W-1:0]   r_best_ratio;

    assign o_in_stall = !((r_state == rob_pkg::ST_IDLE) && (!r_out_valid || !i_out_stall));
    assign in_acc     = i_in_valid && !o_in_stall;
    assign wr_acc     = in_acc && (i_func == rob_pkg::FUNC_WRITE);
    assign last_slot  = r_idx == SLOT_W'(TABLE_SLOTS - 1);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rob_pkg::THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thr <= i_cfg_data;
        end
    end

    assign load_data = {i_entry_valid, COORD_BITS'(i_rect_x), COORD_BITS'(i_rect_y),
                        COORD_BITS'(i_rect_w), COORD_BITS'(i_rect_h)};

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_func == rob_pkg::FUNC_QUERY)) begin
            r_query <= load_data[4*COORD_BITS-1:0];
        end
    end

    for (genvar gi = 0; gi < TABLE_SLOTS; gi++) begin : g_ring
        rob_cell #(
            .DATA_W (DATA_W)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_load      (wr_acc && ({5'd0, i_slot} == 9'(gi))),
            .i_shift     (ring_shift),
            .i_load_data (load_data),
            .i_next_data (cell_data[(gi + 1) % TABLE_SLOTS]),
            .o_data      (cell_data[gi])
        );
    end

    rob_score #(
        .COORD_BITS (COORD_BITS),
        .SLOT_W     (SLOT_W)
    ) u_score (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (score_ctrl),
        .i_thr       (r_thr),
        .i_query     (r_query),
        .i_slot_data (cell_data[0]),
        .i_cand_idx  (r_idx),
        .o_found     (best_found),
        .o_best_slot (best_slot),
        .o_best_num  (best_num),
        .o_best_den  (best_den)
    );

    rob_div #(
        .RW (RW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (best_num),
        .i_den   (best_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rob_pkg::ST_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == rob_pkg::ST_CMP) begin
                r_idx <= last_slot ? '0 : r_idx + 1'b1;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rob_pkg::ST_IDLE: begin
                if (in_acc && (i_func == rob_pkg::FUNC_QUERY)) begin
                    n_state = rob_pkg::ST_GEO;
                end
            end
            rob_pkg::ST_GEO:  n_state = rob_pkg::ST_AREA;
            rob_pkg::ST_AREA: n_state = rob_pkg::ST_XLO;
            rob_pkg::ST_XLO:  n_state = rob_pkg::ST_XHI;
            rob_pkg::ST_XHI:  n_state = rob_pkg::ST_CMP;
            rob_pkg::ST_CMP:  n_state = last_slot ? rob_pkg::ST_FIN : rob_pkg::ST_GEO;
            rob_pkg::ST_FIN:  n_state = best_found ? rob_pkg::ST_DIV : rob_pkg::ST_IDLE;
            rob_pkg::ST_DIV: begin
                if (div_done) begin
                    n_state = rob_pkg::ST_IDLE;
                end
            end
            default: n_state = rob_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        score_ctrl      = '0;
        score_ctrl.init = in_acc && (i_func == rob_pkg::FUNC_QUERY);
        ring_shift      = 1'b0;
        div_start       = 1'b0;
        out_zero_ld     = wr_acc;
        out_match_ld    = 1'b0;
        unique case (r_state)
            rob_pkg::ST_IDLE: ;
            rob_pkg::ST_GEO: begin
                score_ctrl.geo = 1'b1;
                ring_shift     = 1'b1;
            end
            rob_pkg::ST_AREA: score_ctrl.area = 1'b1;
            rob_pkg::ST_XLO:  score_ctrl.xlo  = 1'b1;
            rob_pkg::ST_XHI:  score_ctrl.xhi  = 1'b1;
            rob_pkg::ST_CMP:  score_ctrl.cmp  = 1'b1;
            rob_pkg::ST_FIN: begin
                div_start   = best_found;
                out_zero_ld = !best_found;
            end
            rob_pkg::ST_DIV: out_match_ld = div_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_zero_ld || out_match_ld) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_zero_ld) begin
            r_found      <= 1'b0;
            r_match_slot <= '0;
            r_best_ratio <= '0;
        end else if (out_match_ld) begin
            r_found      <= 1'b1;
            r_match_slot <= rob_pkg::SLOT_FIELD_W'(best_slot);
            r_best_ratio <= div_quot;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_found;
    assign o_match_slot = r_match_slot;
    assign o_best_ratio = r_best_ratio;

`ifndef SYNTHESIS
    a_ring_home: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rob_pkg::ST_FIN) |-> (r_idx == '0))
        else $error("Slot ring is not back at its home position after a query.");

    a_div_in_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == rob_pkg::ST_DIV))
        else $error("Divider finished outside of the divide state.");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_found) |-> (r_best_ratio <= rob_pkg::Q16_ONE))
        else $error("Reported ratio is above one.");

    a_write_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_acc |=> (r_out_valid && !r_found && (r_match_slot == '0) && (r_best_ratio == '0)))
        else $error("A write beat did not produce an empty result.");
`endif

endmodule
